// ----- src/nalscan_pkg.sv -----
package nalscan_pkg;

  localparam int unsigned TYPE_BITS     = 5;
  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned WINDOW_DEPTH  = 5;
  localparam int unsigned LEN_BITS      = 32;
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [TYPE_BITS-1:0] TYPE_MASK          = 5'h1F;
  localparam logic [TYPE_BITS-1:0] WANTED_TYPE_RESET  = 5'd5;
  localparam logic                 RELAXED_TAIL_RESET = 1'b1;

  localparam logic [BYTE_BITS-1:0] CODE_ZERO = 8'h00;
  localparam logic [BYTE_BITS-1:0] CODE_ONE  = 8'h01;

  // Register index is taken from paddr[2].
  typedef logic reg_idx_t;
  localparam reg_idx_t REG_WANTED_TYPE  = 1'b0;
  localparam reg_idx_t REG_RELAXED_TAIL = 1'b1;

  typedef struct packed {
    logic [TYPE_BITS-1:0] wanted_type;
    logic                 relaxed_tail;
  } cfg_t;

  // One byte step as seen by both checks.
  typedef struct packed {
    logic                                    adv;
    logic                                    last;
    logic [BYTE_BITS-1:0]                    cur;
    logic [WINDOW_DEPTH-1:0][BYTE_BITS-1:0]  win;
    logic                                    ge4;
    logic                                    ge5;
    logic                                    sat;
  } step_t;

  function automatic logic type_ok(input logic [BYTE_BITS-1:0] b,
                                   input logic [TYPE_BITS-1:0] wanted);
    type_ok = ((b[TYPE_BITS-1:0] & TYPE_MASK) == wanted);
  endfunction

endpackage

// ----- src/nalscan_in_if.sv -----
interface nalscan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ----- src/nalscan_out_if.sv -----
interface nalscan_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, output found, input ready);
  modport sink   (input valid, input found, output ready);
endinterface

// ----- src/h264_nal_type_scanner.sv -----
// Channel   Modport  Payload               Transfer
// stream    sink     data_byte[7:0], last  valid && ready
// report    source   found                 valid && ready
// APB       slave    wanted_type, relaxed  psel && penable && pwrite
//
// One byte is taken per cycle unless a last byte waits on a stalled result.
// A byte is held in the input register, then both checks evaluate it and
// update their state in a single pass. The result for a buffer is loaded into
// the result register at the edge where its last byte leaves the input
// register, so it can be transferred out only after that edge.
// Reset is synchronous and active high and clears all scan state; the same
// state also clears after each last byte. A stalled result blocks only the
// next last byte; ordinary bytes keep flowing into the checks meanwhile.
module h264_nal_type_scanner #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  nalscan_in_if.sink                            stream,
  nalscan_out_if.source                         report,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [nalscan_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [nalscan_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [nalscan_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                  pready
);

  nalscan_pkg::cfg_t  cfg;
  nalscan_pkg::step_t step;

  // Input register.
  logic                                s1_valid;
  logic [nalscan_pkg::BYTE_BITS-1:0]   s1_byte;
  logic                                s1_last;
  logic                                s1_adv;
  logic                                in_take;

  // Scan position and the window of the five previous bytes, newest at index 0.
  logic [POSITION_BITS-1:0]                                          pos;
  logic [nalscan_pkg::WINDOW_DEPTH-1:0][nalscan_pkg::BYTE_BITS-1:0]  win;

  logic annexb_now;
  logic avcc_now;

  // Result register.
  logic out_valid;
  logic found;

  nalscan_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A byte without the last flag produces no result and always moves on. The
  // last byte moves on only if the result register is free or being emptied.
  assign s1_adv       = s1_valid && (!s1_last || !out_valid || report.ready);
  assign stream.ready = !s1_valid || s1_adv;
  assign in_take      = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= stream.data_byte;
      s1_last <= stream.last;
    end
  end

  always_comb begin
    step.adv  = s1_adv;
    step.last = s1_last;
    step.cur  = s1_byte;
    step.win  = win;
    step.ge4  = pos >= POSITION_BITS'(4);
    step.ge5  = pos >= POSITION_BITS'(5);
    step.sat  = &pos;
  end

  // Position saturates at all ones; the length walk stops there.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      win <= '0;
    end else if (s1_adv) begin
      if (s1_last) begin
        pos <= '0;
        win <= '0;
      end else begin
        if (!step.sat) begin
          pos <= pos + POSITION_BITS'(1);
        end
        win <= {win[nalscan_pkg::WINDOW_DEPTH-2:0], s1_byte};
      end
    end
  end

  nalscan_annexb u_annexb (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .hit_now (annexb_now)
  );

  nalscan_avcc u_avcc (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .hit_now (avcc_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      found <= annexb_now | avcc_now;
    end
  end

  assign report.valid = out_valid;
  assign report.found = found;

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("Result raised without a last byte");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
      s1_valid && s1_last && out_valid && !report.ready |-> !stream.ready)
    else $error("Input taken while a last byte waits for the result register");

  a_pos_clears: assert property (@(posedge clk) disable iff (rst)
      s1_adv && s1_last |=> pos == '0)
    else $error("Position not cleared after the end of a buffer");

endmodule

// ----- src/nalscan_cfg.sv -----
module nalscan_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [nalscan_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [nalscan_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [nalscan_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                  pready,
  output nalscan_pkg::cfg_t                     cfg
);

  logic                 wr_en;
  nalscan_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wanted_type  <= nalscan_pkg::WANTED_TYPE_RESET;
      cfg.relaxed_tail <= nalscan_pkg::RELAXED_TAIL_RESET;
    end else if (wr_en) begin
      case (idx)
        nalscan_pkg::REG_WANTED_TYPE: begin
          cfg.wanted_type <= pwdata[nalscan_pkg::TYPE_BITS-1:0] & nalscan_pkg::TYPE_MASK;
        end
        nalscan_pkg::REG_RELAXED_TAIL: begin
          cfg.relaxed_tail <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      nalscan_pkg::REG_WANTED_TYPE: begin
        prdata[nalscan_pkg::TYPE_BITS-1:0] = cfg.wanted_type;
      end
      nalscan_pkg::REG_RELAXED_TAIL: begin
        prdata[0] = cfg.relaxed_tail;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

// ----- src/nalscan_annexb.sv -----
module nalscan_annexb (
  input  logic                 clk,
  input  logic                 rst,
  input  nalscan_pkg::cfg_t    cfg,
  input  nalscan_pkg::step_t   step,
  output logic                 hit_now
);

  logic annexb_hit;
  logic code3;
  logic code4_relaxed;
  logic code4_generic;
  logic byte_hit;

  // Three-byte code ending just before the header, header is the newest window byte.
  assign code3 = step.ge4
      && step.win[3] == nalscan_pkg::CODE_ZERO
      && step.win[2] == nalscan_pkg::CODE_ZERO
      && step.win[1] == nalscan_pkg::CODE_ONE
      && nalscan_pkg::type_ok(step.win[0], cfg.wanted_type);

  // Four-byte code whose header is the current byte.
  assign code4_relaxed = step.ge4
      && step.win[3] == nalscan_pkg::CODE_ZERO
      && step.win[2] == nalscan_pkg::CODE_ZERO
      && step.win[1] == nalscan_pkg::CODE_ZERO
      && step.win[0] == nalscan_pkg::CODE_ONE
      && nalscan_pkg::type_ok(step.cur, cfg.wanted_type);

  // Four-byte code whose header has one byte after it.
  assign code4_generic = step.ge5
      && step.win[4] == nalscan_pkg::CODE_ZERO
      && step.win[3] == nalscan_pkg::CODE_ZERO
      && step.win[2] == nalscan_pkg::CODE_ZERO
      && step.win[1] == nalscan_pkg::CODE_ONE
      && nalscan_pkg::type_ok(step.win[0], cfg.wanted_type);

  assign byte_hit = code3 | (cfg.relaxed_tail ? code4_relaxed : code4_generic);
  assign hit_now  = annexb_hit | byte_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      annexb_hit <= 1'b0;
    end else if (step.adv) begin
      annexb_hit <= step.last ? 1'b0 : hit_now;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
      step.adv && step.last |=> !annexb_hit)
    else $error("Annex-B hit survived the end of a buffer");

endmodule

// ----- src/nalscan_avcc.sv -----
module nalscan_avcc (
  input  logic                 clk,
  input  logic                 rst,
  input  nalscan_pkg::cfg_t    cfg,
  input  nalscan_pkg::step_t   step,
  output logic                 hit_now
);

  typedef enum logic [3:0] {
    ST_LEN  = 4'b0001,
    ST_HDR  = 4'b0010,
    ST_BODY = 4'b0100,
    ST_STOP = 4'b1000
  } walk_state_t;

  walk_state_t                        state, state_next;
  logic [1:0]                         len_idx, len_idx_next;
  logic [nalscan_pkg::LEN_BITS-1:0]   unit_length, unit_length_next;
  logic [nalscan_pkg::LEN_BITS-1:0]   remain, remain_next;
  logic                               pending, pending_next;
  logic                               walk_hit;
  logic                               hit_set;
  logic                               hdr_match;

  assign hdr_match = nalscan_pkg::type_ok(step.cur, cfg.wanted_type);

  always_comb begin
    state_next       = state;
    len_idx_next     = len_idx;
    unit_length_next = unit_length;
    remain_next      = remain;
    pending_next     = pending;
    hit_set          = 1'b0;
    if (state != ST_STOP && step.sat) begin
      // Position counter saturated: the walk can no longer track offsets.
      state_next   = ST_STOP;
      pending_next = 1'b0;
    end else begin
      case (state)
        ST_LEN: begin
          unit_length_next = {unit_length[nalscan_pkg::LEN_BITS-9:0], step.cur};
          len_idx_next     = len_idx + 2'd1;
          if (len_idx == 2'd3) begin
            state_next = ST_HDR;
          end
        end
        ST_HDR: begin
          if (unit_length == '0) begin
            state_next = ST_STOP;
          end else if (unit_length == nalscan_pkg::LEN_BITS'(1)) begin
            hit_set      = hdr_match;
            pending_next = 1'b0;
            state_next   = ST_LEN;
          end else begin
            pending_next = hdr_match;
            remain_next  = unit_length - nalscan_pkg::LEN_BITS'(1);
            state_next   = ST_BODY;
          end
        end
        ST_BODY: begin
          if (remain == nalscan_pkg::LEN_BITS'(1)) begin
            hit_set      = pending;
            pending_next = 1'b0;
            state_next   = ST_LEN;
          end else begin
            remain_next = remain - nalscan_pkg::LEN_BITS'(1);
          end
        end
        ST_STOP: begin
        end
        default: begin
          state_next = ST_STOP;
        end
      endcase
    end
  end

  assign hit_now = walk_hit | hit_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LEN;
      len_idx  <= 2'd0;
      pending  <= 1'b0;
      walk_hit <= 1'b0;
    end else if (step.adv) begin
      if (step.last) begin
        state    <= ST_LEN;
        len_idx  <= 2'd0;
        pending  <= 1'b0;
        walk_hit <= 1'b0;
      end else begin
        state    <= state_next;
        len_idx  <= len_idx_next;
        pending  <= pending_next;
        walk_hit <= hit_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step.adv) begin
      unit_length <= unit_length_next;
      remain      <= remain_next;
    end
  end

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
      state == ST_STOP && !(step.adv && step.last) |=> state == ST_STOP)
    else $error("Length walk left the stopped state within a buffer");

  a_len_aligned: assert property (@(posedge clk) disable iff (rst)
      state == ST_HDR || state == ST_BODY |-> len_idx == 2'd0)
    else $error("Length prefix counter out of step with the walk");

endmodule

// ----- tb/sv/tb_h264_nal_type_scanner.sv -----
module tb_h264_nal_type_scanner;

  localparam int unsigned TYPE_BITS     = nalscan_pkg::TYPE_BITS;
  localparam int unsigned BYTE_BITS     = nalscan_pkg::BYTE_BITS;
  localparam int unsigned WINDOW_DEPTH  = nalscan_pkg::WINDOW_DEPTH;
  localparam int unsigned LEN_BITS      = nalscan_pkg::LEN_BITS;
  localparam int unsigned APB_ADDR_BITS = nalscan_pkg::APB_ADDR_BITS;
  localparam int unsigned APB_DATA_BITS = nalscan_pkg::APB_DATA_BITS;

  localparam int unsigned POSITION_BITS = 32;
  localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;

  // Shadow of the block: both checks, the register copies and the queue of
  // verdicts still owed for buffers whose last byte has gone in.
  class nal_match_predictor;
    logic [TYPE_BITS-1:0] wanted;
    logic                 relaxed;
    logic [BYTE_BITS-1:0] win [WINDOW_DEPTH];
    longint unsigned      pos;
    longint unsigned      hdr_ofs;
    logic [LEN_BITS-1:0]  unit_len;
    bit                   annexb_seen;
    bit                   hdr_match;
    bit                   walk_hit;
    bit                   walk_done;
    bit                   found_due [$];
    int                   errors;
    int                   bytes_seen;
    int                   buffers;
    int                   hit_count;

    function new();
      wanted = nalscan_pkg::WANTED_TYPE_RESET;
      relaxed = nalscan_pkg::RELAXED_TAIL_RESET;
      errors = 0;
      bytes_seen = 0;
      buffers = 0;
      hit_count = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (win[i]) win[i] = nalscan_pkg::CODE_ZERO;
      pos = 0;
      hdr_ofs = 0;
      unit_len = '0;
      annexb_seen = 0;
      hdr_match = 0;
      walk_hit = 0;
      walk_done = 0;
    endfunction

    function bit is_wanted(logic [BYTE_BITS-1:0] b);
      return b[TYPE_BITS-1:0] == wanted;
    endfunction

    function void take_byte(logic [BYTE_BITS-1:0] cur, logic last);
      longint unsigned p;
      longint unsigned rel;
      bit              closes;
      p = pos;
      bytes_seen++;

      // Annex-B: a three-byte code whose header is followed by this byte.
      if (p >= 4 && win[3] == nalscan_pkg::CODE_ZERO && win[2] == nalscan_pkg::CODE_ZERO &&
          win[1] == nalscan_pkg::CODE_ONE && is_wanted(win[0]))
        annexb_seen = 1;
      // Four-byte code: the relaxed rule takes the header as it arrives, the
      // generic rule wants one more byte behind it.
      if (relaxed) begin
        if (p >= 4 && win[3] == nalscan_pkg::CODE_ZERO && win[2] == nalscan_pkg::CODE_ZERO &&
            win[1] == nalscan_pkg::CODE_ZERO && win[0] == nalscan_pkg::CODE_ONE &&
            is_wanted(cur))
          annexb_seen = 1;
      end else begin
        if (p >= 5 && win[4] == nalscan_pkg::CODE_ZERO && win[3] == nalscan_pkg::CODE_ZERO &&
            win[2] == nalscan_pkg::CODE_ZERO && win[1] == nalscan_pkg::CODE_ONE &&
            is_wanted(win[0]))
          annexb_seen = 1;
      end

      // Length-prefixed walk.
      if (!walk_done) begin
        if (p >= POS_LIMIT) begin
          walk_done = 1;
          hdr_match = 0;
        end else begin
          closes = 1;
          if (p >= hdr_ofs) begin
            rel = p - hdr_ofs;
            if (rel < 4) begin
              unit_len = {unit_len[LEN_BITS-9:0], cur};
              closes = 0;
            end else if (unit_len == 0) begin
              walk_done = 1;
              closes = 0;
            end else begin
              hdr_match = is_wanted(cur);
              hdr_ofs = hdr_ofs + 4 + unit_len;
            end
          end
          // A unit only counts once its final byte is inside the buffer.
          if (closes && p + 1 == hdr_ofs) begin
            if (hdr_match) walk_hit = 1;
            hdr_match = 0;
          end
        end
      end

      for (int i = WINDOW_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = cur;
      if (pos < POS_LIMIT) pos++;

      if (last) begin
        found_due.push_back(annexb_seen || walk_hit);
        buffers++;
        if (annexb_seen || walk_hit) hit_count++;
        clear_scan();
      end
    endfunction

    function void check_found(logic f);
      bit exp;
      if (found_due.size() == 0) begin
        $error("found: expected no transfer, actual %0b", f);
        errors++;
      end else begin
        exp = found_due.pop_front();
        if (f !== exp) begin
          $error("found: expected %0b, actual %0b", exp, f);
          errors++;
        end
      end
    endfunction

    function int pending();
      return found_due.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  nalscan_in_if  stream ();
  nalscan_out_if report ();

  nal_match_predictor sb = new();

  // Bytes of the buffer being built, and the idling knobs of the phase.
  logic [BYTE_BITS-1:0] buf_bytes [$];
  int                   gap_max = 0;
  int                   stall_max = 0;
  int                   burst_left = 0;
  int                   settings = 1;
  int                   hold_left = 0;
  logic                 ready_now = 1'b1;

  h264_nal_type_scanner #(.POSITION_BITS(POSITION_BITS)) dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .report  (report),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Both channels are observed at the rising edge, where a transfer happens.
  // Every byte transfer feeds the predictor; every result transfer is checked
  // against the oldest verdict it owes.
  always @(posedge clk) begin
    if (!rst && stream.valid && stream.ready) sb.take_byte(stream.data_byte, stream.last);
    if (!rst && report.valid && report.ready) sb.check_found(report.found);
  end

  // The result side alternates ready and stalled runs of random length. With
  // stall_max at zero it simply stays ready, which gives the stall-free
  // stretches.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (stall_max == 0) begin
      ready_now = 1'b1;
    end else begin
      ready_now = ~ready_now;
      hold_left = ready_now ? $urandom_range(0, 6) : $urandom_range(0, stall_max - 1);
    end
    report.ready <= ready_now;
  end

  // One APB transfer, entered and left on a falling edge. The idle wait at
  // the end keeps back-to-back transfers from assigning psel twice in a step.
  task automatic apb_transfer(input logic wr, input nalscan_pkg::reg_idx_t idx,
                              input logic [APB_DATA_BITS-1:0] wdata,
                              output logic [APB_DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Reads a register back and compares the bits it defines.
  task automatic check_register(input nalscan_pkg::reg_idx_t idx,
                                input logic [APB_DATA_BITS-1:0] exp);
    logic [APB_DATA_BITS-1:0] mask;
    logic [APB_DATA_BITS-1:0] got;
    mask = (idx == nalscan_pkg::REG_WANTED_TYPE) ? APB_DATA_BITS'(nalscan_pkg::TYPE_MASK)
                                                 : APB_DATA_BITS'(1);
    apb_transfer(1'b0, idx, '0, got);
    if ((got & mask) !== (exp & mask)) begin
      $error("%s: expected %0d, actual %0d",
             (idx == nalscan_pkg::REG_WANTED_TYPE) ? "wanted_type" : "relaxed_tail",
             exp & mask, got & mask);
      sb.errors++;
    end
  endtask

  // Writes a register with random junk above its defined bits, which the
  // block has to drop, then mirrors the value into the predictor.
  task automatic set_register(input nalscan_pkg::reg_idx_t idx,
                              input logic [APB_DATA_BITS-1:0] value);
    logic [APB_DATA_BITS-1:0] mask;
    logic [APB_DATA_BITS-1:0] unused;
    mask = (idx == nalscan_pkg::REG_WANTED_TYPE) ? APB_DATA_BITS'(nalscan_pkg::TYPE_MASK)
                                                 : APB_DATA_BITS'(1);
    apb_transfer(1'b1, idx, ($urandom & ~mask) | (value & mask), unused);
    if (idx == nalscan_pkg::REG_WANTED_TYPE) sb.wanted = value[TYPE_BITS-1:0];
    else sb.relaxed = value[0];
    check_register(idx, value);
  endtask

  // Offers one byte until it is taken, then decides at the next falling edge
  // whether the burst goes on or a gap follows.
  task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic l);
    int gap;
    stream.valid     <= 1'b1;
    stream.data_byte <= b;
    stream.last      <= l;
    do @(posedge clk); while (!stream.ready);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        stream.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_buffer();
    foreach (buf_bytes[i]) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
  endtask

  // Holds the sender off until every verdict owed has been transferred. It
  // always waits for a falling edge first, so valid is never dropped and
  // raised in the same step.
  task automatic pause_until_drained();
    stream.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // A random byte over the whole range.
  function automatic logic [BYTE_BITS-1:0] rand_byte();
    return BYTE_BITS'($urandom_range(0, 255));
  endfunction

  // A header byte that matches the wanted type about half the time.
  function automatic logic [BYTE_BITS-1:0] header_byte();
    logic [BYTE_BITS-TYPE_BITS-1:0] upper;
    upper = (BYTE_BITS-TYPE_BITS)'($urandom_range(0, 7));
    if ($urandom_range(0, 1) == 1) return {upper, sb.wanted};
    return rand_byte();
  endfunction

  // Annex-B stream: optional junk, then units behind three- or four-byte
  // start codes. Short payloads put the buffer end right at the header often.
  function automatic void add_annexb();
    int nals;
    repeat ($urandom_range(0, 2)) buf_bytes.push_back(rand_byte());
    nals = $urandom_range(1, 3);
    repeat (nals) begin
      if ($urandom_range(0, 1) == 1) buf_bytes.push_back(nalscan_pkg::CODE_ZERO);
      buf_bytes.push_back(nalscan_pkg::CODE_ZERO);
      buf_bytes.push_back(nalscan_pkg::CODE_ZERO);
      buf_bytes.push_back(nalscan_pkg::CODE_ONE);
      buf_bytes.push_back(header_byte());
      repeat ($urandom_range(0, 2)) buf_bytes.push_back(rand_byte());
    end
  endfunction

  // Length-prefixed stream: mostly well-formed small units, with a zero
  // length, a huge length or a cut-off tail now and then.
  function automatic void add_avcc();
    int                  units;
    int                  pick;
    int                  extra;
    logic [LEN_BITS-1:0] len;
    units = $urandom_range(1, 3);
    for (int u = 0; u < units; u++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len = '0;
      else if (pick == 1) len = $urandom;
      else len = $urandom_range(1, 5);
      buf_bytes.push_back(len[31:24]);
      buf_bytes.push_back(len[23:16]);
      buf_bytes.push_back(len[15:8]);
      buf_bytes.push_back(len[7:0]);
      if (len == 0) begin
        repeat ($urandom_range(0, 3)) buf_bytes.push_back(rand_byte());
        break;
      end
      buf_bytes.push_back(header_byte());
      extra = (len > 5) ? $urandom_range(0, 3) : len - 1;
      repeat (extra) buf_bytes.push_back(rand_byte());
      if (len > 5) break;
    end
    if ($urandom_range(0, 5) == 0) begin
      extra = $urandom_range(1, 3);
      while (extra > 0 && buf_bytes.size() > 1) begin
        void'(buf_bytes.pop_back());
        extra--;
      end
    end
  endfunction

  // Noise rich in the bytes that make up start codes and headers.
  function automatic void add_noise();
    int pick;
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) buf_bytes.push_back(nalscan_pkg::CODE_ZERO);
      else if (pick < 6) buf_bytes.push_back(nalscan_pkg::CODE_ONE);
      else if (pick < 8) buf_bytes.push_back(header_byte());
      else buf_bytes.push_back(rand_byte());
    end
  endfunction

  // One register setting: drain, wait out the pipeline, write both registers,
  // then stream random buffers until the phase has its share of bytes.
  task automatic run_phase(input logic [TYPE_BITS-1:0] wt, input logic rt, input int gmax,
                           input int smax, input bit each, input int nbytes);
    int sent;
    int kind;
    pause_until_drained();
    repeat (4) @(negedge clk);
    set_register(nalscan_pkg::REG_WANTED_TYPE, APB_DATA_BITS'(wt));
    set_register(nalscan_pkg::REG_RELAXED_TAIL, APB_DATA_BITS'(rt));
    gap_max = gmax;
    stall_max = smax;
    settings++;
    sent = 0;
    while (sent < nbytes) begin
      buf_bytes.delete();
      kind = $urandom_range(0, 19);
      if (kind < 9) add_annexb();
      else if (kind < 17) add_avcc();
      else add_noise();
      send_buffer();
      sent += buf_bytes.size();
      if (each) pause_until_drained();
    end
  endtask

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    stream.valid     = 1'b0;
    stream.data_byte = '0;
    stream.last      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Registers must come out of reset at their documented values.
    check_register(nalscan_pkg::REG_WANTED_TYPE, APB_DATA_BITS'(nalscan_pkg::WANTED_TYPE_RESET));
    check_register(nalscan_pkg::REG_RELAXED_TAIL,
                   APB_DATA_BITS'(nalscan_pkg::RELAXED_TAIL_RESET));

    // Directed buffers under the reset setting (type 5, relaxed tail).
    gap_max = 2;
    stall_max = 2;
    // A single-byte buffer: nothing can be found.
    buf_bytes = {8'h65};
    send_buffer();
    // The window still holds zeros, but a start code must lie inside the
    // buffer, so this does not count.
    buf_bytes = {nalscan_pkg::CODE_ONE, 8'h65, 8'hAA};
    send_buffer();
    // Three-byte start code with a byte after the header: found.
    buf_bytes = {nalscan_pkg::CODE_ZERO, nalscan_pkg::CODE_ZERO, nalscan_pkg::CODE_ONE,
                 8'h65, 8'hAA};
    send_buffer();
    // Same code ending on the header byte: not found.
    buf_bytes = {nalscan_pkg::CODE_ZERO, nalscan_pkg::CODE_ZERO, nalscan_pkg::CODE_ONE, 8'h65};
    send_buffer();
    // Four-byte start code ending on the header; also a one-byte length unit.
    buf_bytes = {nalscan_pkg::CODE_ZERO, nalscan_pkg::CODE_ZERO, nalscan_pkg::CODE_ZERO,
                 nalscan_pkg::CODE_ONE, 8'h65};
    send_buffer();
    // A zero length stops the walk, and no start code is present.
    buf_bytes = {nalscan_pkg::CODE_ZERO, nalscan_pkg::CODE_ZERO, nalscan_pkg::CODE_ZERO,
                 nalscan_pkg::CODE_ZERO, 8'h65};
    send_buffer();
    // Start code before a header of another type, with the largest byte
    // value behind it.
    buf_bytes = {nalscan_pkg::CODE_ZERO, nalscan_pkg::CODE_ZERO, nalscan_pkg::CODE_ONE,
                 8'h61, 8'hFF};
    send_buffer();

    // Random phases over several settings, extremes of the type included.
    // The counter saturation case is out of reach with a 32-bit position in
    // a run of this size; the predictor still models it.
    run_phase(nalscan_pkg::WANTED_TYPE_RESET, 1'b1, 4, 3, 1'b0, 70);
    run_phase('0, 1'b0, 0, 0, 1'b0, 70);
    run_phase(nalscan_pkg::TYPE_MASK, 1'b1, 6, 8, 1'b0, 70);
    run_phase(5'd5, 1'b0, 3, 2, 1'b1, 70);
    run_phase(TYPE_BITS'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 5, 5, 1'b0, 70);
    run_phase(5'd7, 1'b1, 2, 10, 1'b0, 70);

    // Let every owed verdict arrive, then give the pipeline time to show any
    // result transfer that nobody asked for.
    pause_until_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d buffers (%0d expected to match) across %0d settings,",
             sb.bytes_seen, sb.buffers, sb.hit_count, settings);
    $display("with random gaps on the byte side and random stalls on the result side.");
    if (sb.errors == 0) begin
      $display("tb_h264_nal_type_scanner OK");
    end else begin
      $display("tb_h264_nal_type_scanner NOT OK");
    end
    $finish;
  end

  // Watchdog: a correct run needs a small fraction of this.
  initial begin
    #2400000;
    $display("tb_h264_nal_type_scanner NOT OK");
    $finish;
  end

endmodule
